@@ hw/rtl/gyro_step_distance_tracker_assert.svh @@
// Assertion macros of the gyro step and distance tracker checker.
`ifndef GYRO_STEP_DISTANCE_TRACKER_ASSERT_SVH
`define GYRO_STEP_DISTANCE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSTD_ASSERT_NOW(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!(r)) (a) |-> (b)) \
        else $error("gstd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSTD_ASSERT_NEXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) \
        else $error("gstd assertion failed");

`endif

@@ hw/rtl/gstd_pkg.sv @@
// Shared constants and widths of the gyro step and distance tracker.
package gstd_pkg;

    localparam int WINDOW_LEN_DEF = 6;

    localparam int RATE_W   = 16;
    localparam int MOTION_W = 19;
    localparam int STEP_W   = 20;
    localparam int INC_W    = 20;
    localparam int TOTAL_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD   = 1'b1;

    localparam logic [MOTION_W-1:0] MOTION_RESET = 19'd145;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd3851;

    localparam logic [INC_W-1:0]   INC_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

@@ hw/rtl/gstd_if.sv @@
// Request channels of the gyro step and distance tracker: samples in, results out.
interface gstd_sample_if
    import gstd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;

    modport source (output valid, rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

interface gstd_result_if
    import gstd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               is_moving;
    logic               step_taken;
    logic [INC_W-1:0]   distance_increment;
    logic [TOTAL_W-1:0] total_distance;
    logic [COUNT_W-1:0] step_count;

    modport source (output valid, is_moving, step_taken, distance_increment,
                    total_distance, step_count, input ready);
    modport sink   (input valid, is_moving, step_taken, distance_increment,
                    total_distance, step_count, output ready);
endinterface

@@ hw/rtl/gyro_step_distance_tracker.sv @@
// Gyro step and distance tracker: window sums, shared squarer and bit-serial root.
//
//   channel   dir   handshake       payload
//   sample    in    valid/ready     rate_x, rate_y, rate_z
//   result    out   valid/ready     is_moving, step_taken, distance_increment,
//                                   total_distance, step_count
//   config    in    cfg_we          cfg_index, cfg_data
//
// Idle mode: ST_CHECK, then ST_DONE loads the result. Moving mode: ST_CHECK, a three-axis
// squarer pass in ST_SQUARE, a one-bit-per-cycle square root in ST_ROOT (RW = root width,
// 21 at the default window) and ST_UPDATE, then ST_DONE loads the result.
// Sample ready is high only while the sequencer waits for a request.
// A result waits in the output register while the next sample is processed.
// Reset clears the windows, sums, reference, mode and totals and restores the thresholds.
module gyro_step_distance_tracker
    import gstd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gstd_sample_if.sink          sample,
    gstd_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SUM_W  = RATE_W + $clog2(WINDOW_LEN);
    localparam int DIFF_W = SUM_W + 1;
    localparam int MAG_W  = SUM_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ACC_W  = SQ_W + 2;
    localparam int RW     = (ACC_W + 1) / 2;
    localparam int RAD_W  = 2 * RW;
    localparam int CNT_W  = $clog2(RW + 1);
    localparam int EXT_W  = TOTAL_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [MOTION_W-1:0] motion_thr_reg;
    logic [STEP_W-1:0]   step_thr_reg;

    logic signed [RATE_W-1:0] win_reg [3][WINDOW_LEN];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [SUM_W-1:0]  ref_reg [3];
    logic                     moving_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic [2:0]         phase_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [RW:0]        rem_reg;
    logic [RW-1:0]      root_reg;
    logic [CNT_W-1:0]   iter_reg;
    logic               step_reg;
    logic [INC_W-1:0]   inc_reg;

    logic               out_valid_reg;
    logic               out_moving_reg;
    logic               out_step_reg;
    logic [INC_W-1:0]   out_inc_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic signed [RATE_W-1:0] new_rate [3];
    logic                     accept;
    logic                     any_motion;
    logic [1:0]               axis;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         mag_next;
    logic [RW+2:0]            rem_shift;
    logic [RW+2:0]            trial;
    logic                     fits;
    logic [EXT_W-1:0]         total_sum;
    logic                     load_out;

    assign new_rate[0] = sample.rate_x;
    assign new_rate[1] = sample.rate_y;
    assign new_rate[2] = sample.rate_z;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign load_out     = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        any_motion = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (sum_reg[k] < 0)
            begin
                if ((-(SUM_W + 1)'(sum_reg[k])) >= (SUM_W + 1)'(motion_thr_reg))
                begin
                    any_motion = 1'b1;
                end
            end
            else if ((SUM_W + 1)'(sum_reg[k]) >= (SUM_W + 1)'(motion_thr_reg))
            begin
                any_motion = 1'b1;
            end
        end
    end

    assign axis     = phase_reg[1:0];
    assign diff     = DIFF_W'(sum_reg[axis]) - DIFF_W'(ref_reg[axis]);
    assign mag_next = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    assign total_sum = {1'b0, total_reg} + EXT_W'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            motion_thr_reg <= MOTION_RESET;
            step_thr_reg   <= STEP_RESET;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
                ref_reg[k] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    win_reg[k][i] <= '0;
                end
            end
            moving_reg     <= 1'b0;
            total_reg      <= '0;
            count_reg      <= '0;
            phase_reg      <= '0;
            iter_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MOTION_THRESHOLD: motion_thr_reg <= cfg_data[MOTION_W-1:0];
                    CFG_STEP_THRESHOLD:   step_thr_reg   <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            sum_reg[k] <= sum_reg[k] + SUM_W'(new_rate[k])
                                          - SUM_W'(win_reg[k][WINDOW_LEN-1]);
                            win_reg[k][0] <= new_rate[k];
                            for (int i = 1; i < WINDOW_LEN; i++)
                            begin
                                win_reg[k][i] <= win_reg[k][i-1];
                            end
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    step_reg  <= 1'b0;
                    inc_reg   <= '0;
                    phase_reg <= '0;
                    acc_reg   <= '0;
                    if (!moving_reg)
                    begin
                        moving_reg <= any_motion;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    // Difference, square and accumulate run as a three-deep pipe.
                    if (phase_reg < 3'd3)
                    begin
                        mag_reg       <= mag_next;
                        ref_reg[axis] <= sum_reg[axis];
                    end
                    if (phase_reg >= 3'd1 && phase_reg <= 3'd3)
                    begin
                        sq_reg <= mag_reg * mag_reg;
                    end
                    if (phase_reg >= 3'd2)
                    begin
                        acc_reg <= acc_reg + ACC_W'(sq_reg);
                    end
                    if (phase_reg == 3'd4)
                    begin
                        rad_reg   <= RAD_W'(acc_reg + ACC_W'(sq_reg));
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                end
                ST_ROOT:
                begin
                    rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                    if (fits)
                    begin
                        rem_reg  <= (RW + 1)'(rem_shift - trial);
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= (RW + 1)'(rem_shift);
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    if (iter_reg == CNT_W'(RW - 1))
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    if (EXT_W'(root_reg) >= EXT_W'(step_thr_reg))
                    begin
                        step_reg <= 1'b1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    inc_reg    <= (EXT_W'(root_reg) > EXT_W'(INC_MAX)) ?
                                  INC_MAX : INC_W'(root_reg);
                    total_reg  <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    moving_reg <= 1'b0;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        out_moving_reg <= moving_reg;
                        out_step_reg   <= step_reg;
                        out_inc_reg    <= inc_reg;
                        out_total_reg  <= total_reg;
                        out_count_reg  <= count_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.is_moving          = out_moving_reg;
    assign result.step_taken         = out_step_reg;
    assign result.distance_increment = out_inc_reg;
    assign result.total_distance     = out_total_reg;
    assign result.step_count         = out_count_reg;

endmodule

@@ hw/rtl/gstd_checker.sv @@
// Port-level checker of the gyro step and distance tracker and its bind.
`include "gyro_step_distance_tracker_assert.svh"

module gstd_checker
    import gstd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               is_moving,
    input logic               step_taken,
    input logic [INC_W-1:0]   distance_increment,
    input logic [TOTAL_W-1:0] total_distance,
    input logic [COUNT_W-1:0] step_count
);

    // A step is only counted on the sample that leaves moving mode.
    `GSTD_ASSERT_NOW(a_step_leaves_moving, clk, rst_n, out_valid && step_taken, !is_moving)

    // A sample that enters moving mode adds no distance.
    `GSTD_ASSERT_NOW(a_moving_adds_nothing, clk, rst_n, out_valid && is_moving,
        !step_taken && (distance_increment == '0))

    // A counted step leaves a nonzero, saturating step count.
    `GSTD_ASSERT_NOW(a_step_count_nonzero, clk, rst_n, out_valid && step_taken,
        step_count != '0)

    // An accepted request leaves sample ready low in the next cycle.
    `GSTD_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && in_ready, !in_ready)

    // A stalled result holds its totals.
    `GSTD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(total_distance) && $stable(step_count))

endmodule

bind gyro_step_distance_tracker gstd_checker u_gstd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (sample.valid),
    .in_ready           (sample.ready),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .is_moving          (result.is_moving),
    .step_taken         (result.step_taken),
    .distance_increment (result.distance_increment),
    .total_distance     (result.total_distance),
    .step_count         (result.step_count)
);
